>>> rtl/core/bxf_pkg.sv
// bxf_pkg: shared types and constants for the 3x3 box filter.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package bxf_pkg;

    // Image geometry and sample format
    localparam int MAX_ROW_WIDTH = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int ADDR_BITS     = $clog2(MAX_ROW_WIDTH);
    localparam int WIDTH_BITS    = ADDR_BITS + 1;   // holds MAX_ROW_WIDTH itself
    localparam int ROW_BITS      = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Reset values of the configuration registers
    localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = WIDTH_BITS'(16);
    localparam logic [ROW_BITS-1:0]   ROW_COUNT_RESET = ROW_BITS'(16);

    // Sums: three samples per column, nine per window (plus rounding term)
    localparam int COL_BITS = SAMPLE_BITS + 2;
    localparam int SUM_BITS = SAMPLE_BITS + 4;

    // Divide by nine as multiply by reciprocal: floor(x * RECIP >> SHIFT)
    // is exact for every x below 2^SUM_BITS since the error term is < 9.
    localparam int DIV_SHIFT  = SUM_BITS + 4;
    localparam int RECIP_BITS = DIV_SHIFT - 3;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] DIV9_RECIP =
        RECIP_BITS'((64'd1 << DIV_SHIFT) / 64'd9 + 64'd1);

    // Line store entry: {upper row sample, middle row sample}
    localparam int LINE_BITS = 2 * SAMPLE_BITS;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_WIDTH = 2'd0,
        CFG_ROW_COUNT = 2'd1
    } cfg_index_t;

    // Position info for the incoming request
    typedef struct packed {
        logic [ADDR_BITS-1:0] col;
        logic                 emit;   // window around an interior pixel completes
        logic                 last;   // last pixel of the frame; it completes the last interior window
    } pos_info_t;

endpackage

>>> rtl/core/box_filter_3x3_mean.sv
// Top level of the 3x3 box filter: rounded mean of nine neighbors per interior pixel.
// A result reaches the master side through the read stage (line store read as the
// sample is taken), sum stage (window sum) and output register (divide by nine).
// Throughput: one sample per cycle; border pixels give no result. Back-pressure stalls
// only the stages that are full. Reset (rst_n low, asynchronous): positions and window
// cleared, row width and row count 16; line store contents are undefined until written.
`timescale 1ns / 1ps

module box_filter_3x3_mean
    import bxf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Sample stream in
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,   // [15:0] sample
    input  logic                      s_axis_tuser,   // [0] frame_start
    // Result stream out
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,   // [15:0] average
    output logic                      m_axis_tlast    // frame_last
);

    pos_info_t              pos;
    logic                   in_fire;
    logic                   cfg_fire;
    logic                   d_ld;
    logic                   c_ld;
    logic                   b_ld;
    logic                   b_move;
    logic [LINE_BITS-1:0]   line_rd;
    logic [LINE_BITS-1:0]   line_wr;
    logic [SAMPLE_BITS-1:0] line_upper;
    logic [SAMPLE_BITS-1:0] line_middle;
    logic [SUM_BITS-1:0]    sum_round;
    logic [PROD_BITS-1:0]   product;

    // Read stage (B)
    logic                   b_valid_reg;
    logic                   b_valid_next;
    logic [SAMPLE_BITS-1:0] b_sample_reg;
    logic [ADDR_BITS-1:0]   b_addr_reg;
    logic                   b_emit_reg;
    logic                   b_last_reg;
    // Sum stage (C)
    logic                   c_valid_reg;
    logic                   c_valid_next;
    logic [SUM_BITS-1:0]    c_sum_reg;
    logic                   c_last_reg;
    // Output register (D)
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] out_average_reg;
    logic                   out_last_reg;

    // Configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Stage load enables: a stage loads when empty or when it drains
    assign d_ld          = !out_valid_reg || m_axis_tready;
    assign c_ld          = !c_valid_reg || d_ld;
    assign b_ld          = !b_valid_reg || c_ld;
    assign s_axis_tready = b_ld;
    assign in_fire       = s_axis_tvalid && b_ld;
    assign b_move        = b_valid_reg && c_ld;

    bxf_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_fire    (cfg_fire),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_fire     (in_fire),
        .frame_start (s_axis_tuser),
        .pos         (pos)
    );

    // Column entry shifts down: middle row becomes upper, sample becomes middle
    assign line_upper  = line_rd[LINE_BITS-1:SAMPLE_BITS];
    assign line_middle = line_rd[SAMPLE_BITS-1:0];
    assign line_wr     = {line_middle, b_sample_reg};

    bxf_line_store u_line_store (
        .clk     (clk),
        .wr_en   (b_move),
        .wr_addr (b_addr_reg),
        .wr_data (line_wr),
        .rd_en   (in_fire),
        .rd_addr (pos.col),
        .rd_data (line_rd)
    );

    bxf_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (b_move),
        .upper     (line_upper),
        .middle    (line_middle),
        .sample    (b_sample_reg),
        .sum_round (sum_round)
    );

    // Divide by nine through the reciprocal
    assign product = PROD_BITS'(c_sum_reg) * PROD_BITS'(DIV9_RECIP);

    // Valid bits
    always_comb
    begin
        b_valid_next   = b_ld ? s_axis_tvalid : b_valid_reg;
        c_valid_next   = c_ld ? (b_valid_reg && b_emit_reg) : c_valid_reg;
        out_valid_next = d_ld ? c_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            b_addr_reg   <= pos.col;
            b_emit_reg   <= pos.emit;
            b_last_reg   <= pos.last;
        end
        if (c_ld && b_valid_reg && b_emit_reg)
        begin
            c_sum_reg  <= sum_round;
            c_last_reg <= b_last_reg;
        end
        if (d_ld && c_valid_reg)
        begin
            out_average_reg <= product[DIV_SHIFT +: SAMPLE_BITS];
            out_last_reg    <= c_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_average_reg;
    assign m_axis_tlast  = out_last_reg;

    // A stalled read stage keeps its request
    a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_ld |=> b_valid_reg && $stable(b_sample_reg))
        else $error("read stage lost a stalled request");

    // A stalled sum stage keeps its window sum
    a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && !d_ld |=> c_valid_reg && $stable(c_sum_reg))
        else $error("sum stage lost a stalled request");

    // A sum moving on always reaches the output register
    a_c_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && d_ld |=> out_valid_reg)
        else $error("result dropped between sum stage and output");

endmodule

>>> rtl/core/bxf_position.sv
// bxf_position: configuration registers and raster position counters.
// Depends on bxf_pkg.
`timescale 1ns / 1ps

module bxf_position
    import bxf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_fire,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_fire,
    input  logic                     frame_start,
    output pos_info_t                pos
);

    logic [WIDTH_BITS-1:0] row_width_reg;
    logic [WIDTH_BITS-1:0] row_width_next;
    logic [ROW_BITS-1:0]   row_count_reg;
    logic [ROW_BITS-1:0]   row_count_next;
    logic [ADDR_BITS-1:0]  col_reg;
    logic [ADDR_BITS-1:0]  col_next;
    logic [ROW_BITS-1:0]   row_reg;
    logic [ROW_BITS-1:0]   row_next;

    logic [WIDTH_BITS-1:0] width_eff;
    logic [ADDR_BITS-1:0]  col_cur;
    logic [ROW_BITS-1:0]   row_cur;
    logic [WIDTH_BITS-1:0] col_ext;
    logic [WIDTH_BITS-1:0] col_inc;
    logic [ROW_BITS:0]     row_inc;

    // Configuration writes
    always_comb
    begin
        row_width_next = row_width_reg;
        row_count_next = row_count_reg;
        if (cfg_fire)
        begin
            case (cfg_index)
                CFG_ROW_WIDTH: row_width_next = cfg_data[WIDTH_BITS-1:0];
                CFG_ROW_COUNT: row_count_next = cfg_data[ROW_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Row width clamped to 1 .. MAX_ROW_WIDTH
    always_comb
    begin
        if (row_width_reg > WIDTH_BITS'(MAX_ROW_WIDTH))
            width_eff = WIDTH_BITS'(MAX_ROW_WIDTH);
        else if (row_width_reg == '0)
            width_eff = WIDTH_BITS'(1);
        else
            width_eff = row_width_reg;
    end

    // Position of the incoming sample; frame start forces pixel (0,0)
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;
    assign col_ext = {1'b0, col_cur};
    assign col_inc = col_ext + WIDTH_BITS'(1);
    assign row_inc = {1'b0, row_cur} + (ROW_BITS+1)'(1);

    always_comb
    begin
        pos.col  = col_cur;
        pos.emit = (col_cur >= ADDR_BITS'(2)) && (col_ext < width_eff)
                   && (row_cur >= ROW_BITS'(2)) && (row_cur < row_count_reg);
        pos.last = (col_ext == width_eff - WIDTH_BITS'(1))
                   && (row_cur == row_count_reg - ROW_BITS'(1));
    end

    // Advance: column wraps at row width, row wraps at row count
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire)
        begin
            if (col_inc >= width_eff)
            begin
                col_next = '0;
                if (row_inc >= {1'b0, row_count_reg})
                    row_next = '0;
                else
                    row_next = row_inc[ROW_BITS-1:0];
            end
            else
            begin
                col_next = col_inc[ADDR_BITS-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            row_count_reg <= ROW_COUNT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            row_width_reg <= row_width_next;
            row_count_reg <= row_count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end
    end

    // Counters move only on accepted requests
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(col_reg) && $stable(row_reg))
        else $error("position changed without an accepted request");

    // Without frame start the column steps by one or wraps to zero
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !frame_start |=>
            (col_reg == '0) || (col_reg == $past(col_reg) + 1'b1))
        else $error("column position skipped");

    // After a frame start the row is the first or the second one
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_start |=> (row_reg == '0) || (row_reg == ROW_BITS'(1)))
        else $error("row position not reset by frame start");

endmodule

>>> rtl/core/bxf_line_store.sv
// bxf_line_store: the two previous image rows, one entry per column.
// Registered read with write-through bypass. Depends on bxf_pkg.
`timescale 1ns / 1ps

module bxf_line_store
    import bxf_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [LINE_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [LINE_BITS-1:0] rd_data
);

    logic [LINE_BITS-1:0] mem [MAX_ROW_WIDTH];
    logic [LINE_BITS-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port; a same-cycle write to the same column is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bxf_window.sv
// bxf_window: the two previous window columns kept as column sums, and
// the nine-sample window sum with the rounding term. Depends on bxf_pkg.
`timescale 1ns / 1ps

module bxf_window
    import bxf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift,
    input  logic [SAMPLE_BITS-1:0] upper,
    input  logic [SAMPLE_BITS-1:0] middle,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SUM_BITS-1:0]    sum_round
);

    logic [COL_BITS-1:0] col1_reg;   // column c-1
    logic [COL_BITS-1:0] col1_next;
    logic [COL_BITS-1:0] col2_reg;   // column c-2
    logic [COL_BITS-1:0] col2_next;
    logic [COL_BITS-1:0] col_new;

    // Sum of the column completed by the current sample
    assign col_new = COL_BITS'(upper) + COL_BITS'(middle) + COL_BITS'(sample);

    // Window sum plus 4 for round-to-nearest on divide by nine
    assign sum_round = SUM_BITS'(col_new) + SUM_BITS'(col1_reg)
                       + SUM_BITS'(col2_reg) + SUM_BITS'(4);

    // Column shift on every request leaving the read stage
    always_comb
    begin
        col1_next = col1_reg;
        col2_next = col2_reg;
        if (shift)
        begin
            col1_next = col_new;
            col2_next = col1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col1_reg <= '0;
            col2_reg <= '0;
        end
        else
        begin
            col1_reg <= col1_next;
            col2_reg <= col2_next;
        end
    end

endmodule
